FILE: hdl/pbd_pkg.sv
package pbd_pkg;

  // fixed field and format constants
  localparam int unsigned MAX_RUN     = 128;
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned GRP_W       = $clog2(MAX_RESULTS);
  localparam int unsigned TOTAL_W     = 11;   // up to MAX_RUN * 8 pixels per byte
  localparam int unsigned CFG_DATA_W  = 20;
  localparam int unsigned EMIT_W      = 21;
  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration register indexes
  typedef enum logic {
    REG_PIXEL_DEPTH = 1'b0,
    REG_PIXEL_LIMIT = 1'b1
  } cfg_reg_e;

  // input request
  typedef struct packed {
    logic [7:0] code_byte;
    logic       end_of_segment;
  } in_t;

  // output request: one pixel group
  typedef struct packed {
    logic [63:0] pixels_low;
    logic [63:0] pixels_high;
    logic [4:0]  pixel_count;
    logic        last_of_item;
  } out_t;

  // expansion job handed from the front to the back
  typedef struct packed {
    logic [63:0]        unit;    // expanded pixels of one byte, pixel 0 low
    logic [1:0]         ulog;    // log2 of pixels per byte
    logic [TOTAL_W-1:0] total;   // pixels to emit, nonzero
  } job_t;

endpackage

FILE: hdl/packbits_decoder_depth_unpack_top.sv
// PackBits decoder with pixel-depth unpacking. The front stage parses one compressed
// byte per cycle while the queue has room (headers, repeat byte, literal bytes), expands
// it by pixel_depth and queues a job in a two-entry queue; the back stage emits one pixel
// group of up to PIXELS_PER_GROUP pixels per cycle while the output does not stall. A byte
// that yields P pixels occupies the back stage for ceil(P / PIXELS_PER_GROUP) groups (at
// most 64) and no new job is taken before its last group is registered; a long run (up to
// 1024 pixels at 1 bit per pixel) holds the input, once the queue is full, until its
// groups drain through the output register. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i only while idle, a rule for the user the block does not enforce.
module packbits_decoder_depth_unpack_top #(
  parameter int unsigned PIXELS_PER_GROUP = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  pbd_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output pbd_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  pbd_pkg::cfg_reg_e              cfg_idx_i,
  input  logic [pbd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic          fj_valid;
  logic          fj_ready;
  pbd_pkg::job_t fj_data;
  logic          bj_valid;
  logic          bj_ready;
  pbd_pkg::job_t bj_data;

  // byte parser and expander
  pbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .job_valid_o (fj_valid),
    .job_ready_i (fj_ready),
    .job_o       (fj_data)
  );

  // job queue
  pbd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fj_valid),
    .push_ready_o (fj_ready),
    .push_data_i  (fj_data),
    .pop_valid_o  (bj_valid),
    .pop_ready_i  (bj_ready),
    .pop_data_o   (bj_data)
  );

  // group emitter
  pbd_back #(
    .PIXELS_PER_GROUP (PIXELS_PER_GROUP)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (bj_valid),
    .job_ready_o (bj_ready),
    .job_i       (bj_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: hdl/pbd_front.sv
module pbd_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  pbd_pkg::in_t                      in_data_i,
  input  logic                              cfg_we_i,
  input  pbd_pkg::cfg_reg_e                 cfg_idx_i,
  input  logic [pbd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                              job_valid_o,
  input  logic                              job_ready_i,
  output pbd_pkg::job_t                     job_o
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2
  } phase_e;

  localparam logic [pbd_pkg::EMIT_W-1:0] EMIT_MAX = '1;

  logic [5:0]                     depth_q;
  logic [19:0]                    limit_q;
  phase_e                         phase_q, phase_d;
  logic [7:0]                     rem_q, rem_d;
  logic [7:0]                     rep_q, rep_d;
  logic [pbd_pkg::EMIT_W-1:0]     emit_q, emit_d;

  logic [7:0]                     b;
  logic [7:0]                     reps;
  logic [7:0]                     rem_dec;
  logic [63:0]                    unit;
  logic [1:0]                     ulog;
  logic [pbd_pkg::TOTAL_W-1:0]    total;
  logic [pbd_pkg::EMIT_W:0]       emit_sum;
  logic                           accept;

  assign b          = in_data_i.code_byte;
  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i && job_ready_i;

  // expand one byte by pixel depth
  always_comb begin
    unit = '0;
    ulog = 2'd0;
    unique case (depth_q)
      6'd1: begin
        ulog = 2'd3;
        for (int k = 0; k < 8; k++) begin
          unit[k*8 +: 8] = b[7-k] ? 8'd0 : 8'd255;
        end
      end
      6'd2: begin
        ulog = 2'd2;
        for (int k = 0; k < 4; k++) begin
          unit[k*8 +: 8] = {6'd0, b[7-2*k -: 2]};
        end
      end
      6'd4: begin
        ulog = 2'd1;
        unit[7:0]  = {4'd0, b[7:4]};
        unit[15:8] = {4'd0, b[3:0]};
      end
      default: begin
        unit[7:0] = b;
      end
    endcase
  end

  // packet parser
  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    rep_d   = rep_q;
    reps    = 8'd0;
    rem_dec = (rem_q != 8'd0) ? rem_q - 8'd1 : 8'd0;
    unique case (phase_q)
      PH_REPEAT: begin
        reps    = rep_q;
        phase_d = PH_HEADER;
      end
      PH_LITERAL: begin
        reps    = 8'd1;
        rem_d   = rem_dec;
        phase_d = (rem_dec == 8'd0) ? PH_HEADER : PH_LITERAL;
      end
      default: begin
        phase_d = PH_HEADER;
        if (emit_q < {1'b0, limit_q} && b != 8'd128) begin
          if (b > 8'd128) begin
            rep_d   = 8'(9'd257 - {1'b0, b});
            phase_d = PH_REPEAT;
          end else begin
            rem_d   = b + 8'd1;
            phase_d = PH_LITERAL;
          end
        end
      end
    endcase

    total    = pbd_pkg::TOTAL_W'({3'd0, reps} << ulog);
    emit_sum = {1'b0, emit_q} + (pbd_pkg::EMIT_W + 1)'(total);
    emit_d   = emit_sum[pbd_pkg::EMIT_W] ? EMIT_MAX : emit_sum[pbd_pkg::EMIT_W-1:0];

    // end of segment resets the parser
    if (in_data_i.end_of_segment) begin
      phase_d = PH_HEADER;
      rem_d   = 8'd0;
      rep_d   = 8'd0;
      emit_d  = '0;
    end
  end

  assign job_valid_o = in_valid_i && (total != '0);
  assign job_o.unit  = unit;
  assign job_o.ulog  = ulog;
  assign job_o.total = total;

  // parser state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= 6'd8;
      limit_q <= 20'hFFFFF;
      phase_q <= PH_HEADER;
      rem_q   <= 8'd0;
      rep_q   <= 8'd0;
      emit_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pbd_pkg::REG_PIXEL_DEPTH: depth_q <= cfg_data_i[5:0];
          pbd_pkg::REG_PIXEL_LIMIT: limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        phase_q <= phase_d;
        rem_q   <= rem_d;
        rep_q   <= rep_d;
        emit_q  <= emit_d;
      end
    end
  end

endmodule

FILE: hdl/pbd_queue.sv
module pbd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  pbd_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output pbd_pkg::job_t pop_data_o
);

  localparam int unsigned PTR_W = $clog2(pbd_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(pbd_pkg::QUEUE_DEPTH + 1);

  pbd_pkg::job_t     mem_q [pbd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              push;
  logic              pop;

  assign push_ready_o = (cnt_q != CNT_W'(pbd_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(pbd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(pbd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(pbd_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");
`endif

endmodule

FILE: hdl/pbd_back.sv
module pbd_back #(
  parameter int unsigned PIXELS_PER_GROUP = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  pbd_pkg::job_t job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pbd_pkg::out_t out_data_o
);

  localparam logic [pbd_pkg::GRP_W-1:0]   GRP_LAST = pbd_pkg::GRP_W'(pbd_pkg::MAX_RESULTS - 1);
  localparam logic [pbd_pkg::TOTAL_W-1:0] GROUP_T  = pbd_pkg::TOTAL_W'(PIXELS_PER_GROUP);

  logic                          busy_q;
  logic [63:0]                   unit_q;
  logic [2:0]                    mask_q;
  logic [pbd_pkg::TOTAL_W-1:0]   left_q;
  logic [2:0]                    off_q;
  logic [pbd_pkg::GRP_W-1:0]     grp_q;
  logic                          out_valid_q;
  pbd_pkg::out_t                 out_q;

  logic                          adv;
  logic                          take;
  logic [4:0]                    n;
  logic                          last;
  logic [127:0]                  pix;
  logic [2:0]                    sel;

  assign job_ready_o = !busy_q;
  assign take        = job_valid_i && !busy_q;
  assign adv         = busy_q && (!out_valid_q || out_ready_i);

  // build one group from the repeating unit
  always_comb begin
    pix = '0;
    sel = '0;
    n   = (left_q >= GROUP_T) ? 5'(PIXELS_PER_GROUP) : left_q[4:0];
    for (int k = 0; k < PIXELS_PER_GROUP; k++) begin
      sel = (off_q + 3'(k)) & mask_q;
      if (5'(k) < n) begin
        pix[k*8 +: 8] = unit_q[sel*8 +: 8];
      end
    end
    last = (left_q == pbd_pkg::TOTAL_W'(n)) || (grp_q == GRP_LAST);
  end

  // job and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (take) begin
        busy_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.pixels_low   <= pix[63:0];
      out_q.pixels_high  <= pix[127:64];
      out_q.pixel_count  <= n;
      out_q.last_of_item <= last;
      left_q             <= left_q - pbd_pkg::TOTAL_W'(n);
      off_q              <= off_q + n[2:0];
      grp_q              <= grp_q + 1'b1;
    end
    if (take) begin
      unit_q <= job_i.unit;
      mask_q <= 3'((4'd1 << job_i.ulog) - 4'd1);
      left_q <= job_i.total;
      off_q  <= 3'd0;
      grp_q  <= '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pixel_count != 5'd0) &&
                    (out_data_o.pixel_count <= 5'(PIXELS_PER_GROUP)))
    else $error("group pixel count out of range");
  a_busy_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> left_q != '0)
    else $error("busy with no pixels left");
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last) |=> !busy_q && out_data_o.last_of_item)
    else $error("final group did not release the job");
`endif

endmodule
